FILE: design/angular_coverage_checker_core_macros.svh
// ----------------------------------------------------------------------------
// Angular coverage checker assertion macros
// Shared concurrent assertion wrappers clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ANGULAR_COVERAGE_CHECKER_CORE_MACROS_SVH
`define ANGULAR_COVERAGE_CHECKER_CORE_MACROS_SVH

// Checked on every edge outside of reset.
`define ACC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define ACC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/acc_pkg.sv
// ----------------------------------------------------------------------------
// Angular coverage checker package
// Widths, reset values, codes and shared types of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acc_pkg;

  // Field widths.
  localparam int AngleW   = 31;
  localparam int KindW    = 2;
  localparam int EntriesW = 7;
  localparam int CfgIdxW  = 2;

  // Default store depth.
  localparam int AccCapacity = 64;

  // Smallest set that can surround a point.
  localparam int MinEntries = 6;

  // Register reset values: 72 and 30 degrees of a 2^31 turn.
  localparam logic [AngleW-1:0] GapLimitRst  = 31'd429496730;
  localparam logic [AngleW-1:0] ThinLimitRst = 31'd178956971;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgGapLimit   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgThinLimit  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgThinParity = 2'd2;

  // Item kinds; the unused code behaves as a check.
  typedef enum logic [KindW-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_CHECK  = 2'd2
  } kind_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_SRCH  = 3'd1,
    S_SHIFT = 3'd2,
    S_WALK  = 3'd3,
    S_OUT   = 3'd4
  } state_e;

  // Flags from the shared gap unit.
  typedef struct packed {
    logic borrow;
    logic zero;
    logic below_gap;
    logic below_thin;
  } gap_res_t;

endpackage

FILE: design/acc_in_if.sv
// ----------------------------------------------------------------------------
// Angular coverage checker input channel
// Valid/ready channel carrying one item: kind and angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface acc_in_if
  import acc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [AngleW-1:0] angle;

  modport source (output valid, output kind, output angle, input ready);
  modport sink (input valid, input kind, input angle, output ready);
endinterface

FILE: design/acc_out_if.sv
// ----------------------------------------------------------------------------
// Angular coverage checker output channel
// Valid/ready channel carrying one result: surrounded, entries, overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface acc_out_if
  import acc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                surrounded;
  logic [EntriesW-1:0] entries;
  logic                overflow;

  modport source (output valid, output surrounded, output entries, output overflow,
                  input ready);
  modport sink (input valid, input surrounded, input entries, input overflow,
                output ready);
endinterface

FILE: design/angular_coverage_checker_core.sv
// ----------------------------------------------------------------------------
// Angular coverage checker core
// Sorted angle set with clear, insert, surround check and thinning of clusters.
// ----------------------------------------------------------------------------
// The set of n angles lives in a single-port-read, single-port-write store and
// the search and the walk go through one shared subtract-and-compare unit, one
// entry per cycle. A clear beat goes from the accept cycle to the result cycle.
// A check beat passes through the accept cycle, one read per entry for the walk
// behind the registered read port, and the result cycle. An insert beat first
// searches for the slot and then shifts the entries above the new angle up by
// one, and the walk then runs over n + 1 entries. A duplicate or dropped insert
// skips the shift. The input is taken only while the sequencer is idle; the
// finished result waits in an output register, so a new beat may start before
// it is taken, but a result still waiting there holds the sequencer in its
// result cycle. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "angular_coverage_checker_core_macros.svh"

module angular_coverage_checker_core
  import acc_pkg::*;
#(
  parameter int CAPACITY = AccCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  acc_in_if.sink             in_i,
  acc_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [AngleW-1:0]  cfg_wdata_i
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Configuration registers.
  logic [AngleW-1:0] gap_limit_q, thin_limit_q;
  logic              thin_parity_q;

  // Control state.
  state_e        state_q, state_d;
  logic [CW-1:0] held_q, held_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rvld_q, rvld_d;
  logic          out_valid_q, out_valid_d;

  // Working payload.
  logic [AngleW-1:0] a_q, a_d;
  logic [AngleW-1:0] prev1_q, prev1_d;
  logic [AngleW-1:0] first_q, first_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     w_q, w_d;
  logic [AW-1:0]     shw_q, shw_d;
  logic              ok_q, ok_d;
  logic              ovf_q, ovf_d;
  logic              thin1_q, thin1_d;

  // Result register.
  logic                out_surr_q;
  logic [EntriesW-1:0] out_ent_q;
  logic                out_ovf_q;
  logic                out_load;

  // Angle store.
  logic [AngleW-1:0] store_q [CAPACITY];
  logic [AngleW-1:0] rd_data_q;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [AngleW-1:0] wr_data;

  // Shared unit.
  logic [AngleW-1:0] unit_x, unit_y;
  gap_res_t          gap_res;

  logic [CW-1:0] p;
  logic [CW-1:0] sidx_m1;
  logic          drop;
  logic          start_walk;

  assign p       = idx_q - CW'(1);
  assign sidx_m1 = idx_q - CW'(1);

  acc_gap_unit u_gap (
    .x_i          (unit_x),
    .y_i          (unit_y),
    .gap_limit_i  (gap_limit_q),
    .thin_limit_i (thin_limit_q),
    .res_o        (gap_res)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q   <= GapLimitRst;
      thin_limit_q  <= ThinLimitRst;
      thin_parity_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGapLimit:   gap_limit_q   <= cfg_wdata_i;
        CfgThinLimit:  thin_limit_q  <= cfg_wdata_i;
        CfgThinParity: thin_parity_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Store with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= store_q[rd_addr];
    end
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
  end

  // Sequencer next state and datapath control.
  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    idx_d       = idx_q;
    rvld_d      = rvld_q;
    out_valid_d = out_valid_q;
    a_d         = a_q;
    prev1_d     = prev1_q;
    first_d     = first_q;
    pos_d       = pos_q;
    w_d         = w_q;
    shw_d       = shw_q;
    ok_d        = ok_q;
    ovf_d       = ovf_q;
    thin1_d     = thin1_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = w_q[AW-1:0];
    wr_data     = prev1_q;
    unit_x      = rd_data_q;
    unit_y      = prev1_q;
    drop        = 1'b0;
    start_walk  = 1'b0;
    out_load    = 1'b0;

    // The result register drains independently of the sequencer.
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          a_d   = in_i.angle;
          ovf_d = 1'b0;
          case (in_i.kind)
            KIND_CLEAR: begin
              held_d  = '0;
              ok_d    = 1'b0;
              state_d = S_OUT;
            end
            KIND_INSERT: begin
              idx_d   = '0;
              rvld_d  = 1'b0;
              state_d = S_SRCH;
            end
            default: begin
              start_walk = 1'b1;
            end
          endcase
        end
      end

      // Find the first entry not below the new angle.
      S_SRCH: begin
        unit_y = a_q;
        if (idx_q < held_q) begin
          rd_en  = 1'b1;
          idx_d  = idx_q + CW'(1);
          rvld_d = 1'b1;
        end else begin
          rvld_d = 1'b0;
        end
        if ((rvld_q && !gap_res.borrow) || (!rvld_q && idx_q == held_q)) begin
          if (rvld_q && gap_res.zero) begin
            start_walk = 1'b1;
          end else if (held_q == CW'(CAPACITY)) begin
            ovf_d      = 1'b1;
            start_walk = 1'b1;
          end else begin
            pos_d   = rvld_q ? p : held_q;
            idx_d   = held_q;
            rvld_d  = 1'b0;
            state_d = S_SHIFT;
          end
        end
      end

      // Move entries up by one from the top down, then drop the angle in.
      S_SHIFT: begin
        if (rvld_q) begin
          wr_en   = 1'b1;
          wr_addr = shw_q;
          wr_data = rd_data_q;
        end
        if (idx_q > pos_q) begin
          rd_en   = 1'b1;
          rd_addr = sidx_m1[AW-1:0];
          shw_d   = idx_q[AW-1:0];
          idx_d   = sidx_m1;
          rvld_d  = 1'b1;
        end else begin
          rvld_d = 1'b0;
          if (!rvld_q) begin
            wr_en      = 1'b1;
            wr_addr    = pos_q[AW-1:0];
            wr_data    = a_q;
            held_d     = held_q + CW'(1);
            start_walk = 1'b1;
          end
        end
      end

      // Check the gaps and compact the kept entries in place.
      S_WALK: begin
        if (idx_q < held_q) begin
          rd_en  = 1'b1;
          idx_d  = idx_q + CW'(1);
          rvld_d = 1'b1;
        end else begin
          rvld_d = 1'b0;
        end
        if (rvld_q) begin
          if (p == '0) begin
            first_d = rd_data_q;
          end else begin
            if (!gap_res.below_gap) begin
              ok_d = 1'b0;
            end
            drop = (p >= CW'(2)) && (p[0] == thin_parity_q) &&
                   gap_res.below_thin && thin1_q;
            if (!drop) begin
              wr_en = 1'b1;
              w_d   = w_q + CW'(1);
            end
            thin1_d = gap_res.below_thin;
          end
          prev1_d = rd_data_q;
        end else if (idx_q == held_q) begin
          // Last entry is always kept; close the circle with the wrap gap.
          unit_x = first_q;
          held_d = w_q;
          if (held_q != '0) begin
            wr_en  = 1'b1;
            held_d = w_q + CW'(1);
            if (!gap_res.below_gap) begin
              ok_d = 1'b0;
            end
          end
          state_d = S_OUT;
        end
      end

      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (start_walk) begin
      idx_d   = '0;
      rvld_d  = 1'b0;
      w_d     = '0;
      thin1_d = 1'b0;
      ok_d    = (held_d >= CW'(MinEntries));
      state_d = S_WALK;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      idx_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      idx_q       <= idx_d;
      rvld_q      <= rvld_d;
      out_valid_q <= out_valid_d;
      ovf_q       <= ovf_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    prev1_q <= prev1_d;
    first_q <= first_d;
    pos_q   <= pos_d;
    w_q     <= w_d;
    shw_q   <= shw_d;
    ok_q    <= ok_d;
    thin1_q <= thin1_d;
    if (out_load) begin
      out_surr_q <= ok_q;
      out_ent_q  <= EntriesW'(held_q);
      out_ovf_q  <= ovf_q;
    end
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.surrounded = out_surr_q;
  assign out_o.entries    = out_ent_q;
  assign out_o.overflow   = out_ovf_q;

  // Assertions.
  `ACC_ASSERT(a_held_bound, held_q <= CW'(CAPACITY), "held count exceeds capacity")
  `ACC_ASSERT(a_walk_wr_behind, (state_q == S_WALK && wr_en) |-> (w_q < idx_q), "write ahead of read")
  `ACC_ASSERT(a_ovf_full, $rose(ovf_q) |-> (held_q == CW'(CAPACITY)), "overflow with room left")
  `ACC_ASSERT(a_accept_leaves_idle, (in_i.valid && in_i.ready) |=> (state_q != S_IDLE), "beat not started")
  `ACC_ASSERT(a_out_hold, (state_q == S_OUT && out_valid_q && !out_o.ready) |=> (state_q == S_OUT), "result lost")

endmodule

FILE: design/acc_gap_unit.sv
// ----------------------------------------------------------------------------
// Angular coverage checker gap unit
// Shared subtractor and limit compares for the search and the walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acc_gap_unit
  import acc_pkg::*;
(
  input  logic [AngleW-1:0] x_i,
  input  logic [AngleW-1:0] y_i,
  input  logic [AngleW-1:0] gap_limit_i,
  input  logic [AngleW-1:0] thin_limit_i,
  output gap_res_t          res_o
);

  logic [AngleW:0]   diff;
  logic [AngleW-1:0] gap;

  // One wide subtract: the low bits are the circular gap, the top bit the borrow.
  assign diff = {1'b0, x_i} - {1'b0, y_i};
  assign gap  = diff[AngleW-1:0];

  assign res_o.borrow     = diff[AngleW];
  assign res_o.zero       = (gap == '0);
  assign res_o.below_gap  = (gap < gap_limit_i);
  assign res_o.below_thin = (gap < thin_limit_i);

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Angular coverage checker core testbench
// Drives clear, insert and check beats through the valid/ready channels under
// several idle and stall patterns and register settings. Each accepted beat is
// run through a sorted-set predictor in the bench, and every result beat is
// compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import acc_pkg::*;

  // The fourth kind code has no enum name; the core treats it as a check.
  localparam logic [KindW-1:0]  KindUnused = 2'd3;
  localparam logic [AngleW-1:0] AngleMax   = '1;
  localparam logic [AngleW-1:0] Deg60      = 31'd357913941;
  localparam logic [AngleW:0]   FullTurn   = 32'h8000_0000;

  typedef struct packed {
    logic                surrounded;
    logic [EntriesW-1:0] entries;
    logic                overflow;
  } coverage_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [AngleW-1:0]  cfg_wdata;

  acc_in_if  in_if ();
  acc_out_if out_if ();

  angular_coverage_checker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: the sorted angle set and its register copies.
  logic [AngleW-1:0] model_angles [AccCapacity];
  int unsigned       model_count;
  logic [AngleW-1:0] lim_gap;
  logic [AngleW-1:0] lim_thin;
  logic              par_thin;
  logic [AngleW-1:0] last_angle;

  coverage_t   pending_results[$];
  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_cycles;

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t ns: mismatch in %s on result %0d: got %0d, expected %0d",
             $time, what, results_seen, got, want);
    fail_count++;
  endtask

  // Applies one beat to the predicted set and returns the result it yields.
  task automatic predict_coverage(input logic [KindW-1:0] kind,
                                  input logic [AngleW-1:0] ang, output coverage_t res);
    int unsigned       pos;
    int unsigned       w;
    logic              all_gaps_ok;
    logic              drop [AccCapacity];
    logic [AngleW-1:0] gap_hi;
    logic [AngleW-1:0] gap_lo;
    res = '0;
    if (kind == KIND_CLEAR) begin
      model_count = 0;
    end else begin
      // Sorted insert; a duplicate is ignored and a full set drops the angle.
      if (kind == KIND_INSERT) begin
        pos = 0;
        while (pos < model_count && model_angles[pos] < ang) pos++;
        if (pos < model_count && model_angles[pos] == ang) begin
          res.overflow = 1'b0;
        end else if (model_count >= AccCapacity) begin
          res.overflow = 1'b1;
        end else begin
          for (int i = int'(model_count); i > int'(pos); i--) begin
            model_angles[i] = model_angles[i-1];
          end
          model_angles[pos] = ang;
          model_count++;
        end
      end

      // Walk the set: gap check and thinning marks, all on the unthinned set.
      all_gaps_ok = (model_count >= MinEntries);
      foreach (drop[i]) drop[i] = 1'b0;
      for (int unsigned p = 1; p < model_count; p++) begin
        gap_hi = model_angles[p] - model_angles[p-1];
        if (gap_hi >= lim_gap) all_gaps_ok = 1'b0;
        if (p >= 2 && p[0] == par_thin) begin
          gap_lo = model_angles[p-1] - model_angles[p-2];
          if (gap_hi < lim_thin && gap_lo < lim_thin) drop[p-1] = 1'b1;
        end
      end
      if (model_count > 0) begin
        gap_hi = model_angles[0] - model_angles[model_count-1];
        if (gap_hi >= lim_gap) all_gaps_ok = 1'b0;
      end

      // Compact the survivors.
      w = 0;
      for (int unsigned p = 0; p < model_count; p++) begin
        if (!drop[p]) begin
          model_angles[w] = model_angles[p];
          w++;
        end
      end
      model_count    = w;
      res.surrounded = all_gaps_ok;
      res.entries    = EntriesW'(model_count);
    end
  endtask

  // Offers one beat, waits for it to be taken and records its prediction.
  task automatic send_item(input logic [KindW-1:0] kind, input logic [AngleW-1:0] ang);
    coverage_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind  <= kind;
    in_if.angle <= ang;
    do @(posedge clk_i); while (!in_if.ready);
    predict_coverage(kind, ang, res);
    pending_results.insert(pending_results.size(), res);
    if (kind == KIND_INSERT) last_angle = ang;
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes one register; the core must be idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [AngleW-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CfgGapLimit:   lim_gap = data;
      CfgThinLimit:  lim_thin = data;
      CfgThinParity: par_thin = data[0];
      default: ;
    endcase
  endtask

  task automatic config_all(input logic [AngleW-1:0] gap, input logic [AngleW-1:0] thin,
                            input logic [AngleW-1:0] parity_word);
    drain();
    write_reg(CfgGapLimit, gap);
    write_reg(CfgThinLimit, thin);
    write_reg(CfgThinParity, parity_word);
  endtask

  function automatic logic [AngleW-1:0] rand_angle();
    return AngleW'($urandom);
  endfunction

  // Angle for an insert: uniform, near the last one, from a tiny pool,
  // at the wrap extremes, or on an even spread around the circle.
  function automatic logic [AngleW-1:0] pick_angle(input int unsigned spread,
                                                   input logic [AngleW-1:0] base);
    logic [AngleW-1:0] step;
    step = AngleW'(FullTurn / spread);
    case ($urandom_range(9))
      0, 1, 2, 3: return rand_angle();
      4:          return last_angle + AngleW'($urandom_range(1 << 24));
      5:          return last_angle - AngleW'($urandom_range(1 << 24));
      6:          return base + AngleW'($urandom_range(3));
      7: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return AngleMax;
          2:       return AngleW'(1);
          default: return AngleMax - AngleW'(1);
        endcase
      end
      default: return base + AngleW'($urandom_range(spread - 1)) * step
                      + AngleW'($urandom_range(1 << 20));
    endcase
  endfunction

  // Register setting for a random stretch, extremes included.
  task automatic random_config();
    logic [AngleW-1:0] gap;
    logic [AngleW-1:0] thin;
    case ($urandom_range(5))
      0:       gap = '0;
      1:       gap = AngleMax;
      2:       gap = GapLimitRst;
      3, 4:    gap = AngleW'(FullTurn / $urandom_range(4, 10));
      default: gap = rand_angle();
    endcase
    case ($urandom_range(5))
      0:       thin = '0;
      1:       thin = AngleMax;
      2, 3:    thin = ThinLimitRst;
      4:       thin = AngleW'($urandom_range(1 << 28));
      default: thin = rand_angle();
    endcase
    config_all(gap, thin, rand_angle());
  endtask

  // Result beat checker.
  always @(posedge clk_i) begin
    coverage_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected", out_if.entries, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.surrounded !== want.surrounded)
          report_mismatch("surrounded", out_if.surrounded, want.surrounded);
        if (out_if.entries !== want.entries)
          report_mismatch("entries", out_if.entries, want.entries);
        if (out_if.overflow !== want.overflow)
          report_mismatch("overflow", out_if.overflow, want.overflow);
      end
    end
  end

  // Result sink: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_if.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Extremes, every kind, duplicates, the first surround and thinning.
  task automatic test_directed();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    send_item(KIND_CHECK, '0);
    send_item(KindUnused, AngleMax);
    send_item(KIND_INSERT, '0);
    send_item(KIND_INSERT, AngleMax);
    send_item(KIND_INSERT, '0);
    send_item(KIND_CLEAR, AngleMax);
    // Six angles 60 degrees apart surround the point on the sixth insert.
    for (int k = 0; k < 6; k++) send_item(KIND_INSERT, AngleW'(k) * Deg60);
    // A tight cluster at zero thins its middle entry.
    send_item(KIND_INSERT, AngleW'(1));
    send_item(KIND_INSERT, AngleW'(2));
    send_item(KindUnused, '0);
    send_item(KIND_CHECK, AngleMax);
    send_item(KIND_CLEAR, '0);
    // Thinning also applies to a set too small to surround.
    send_item(KIND_INSERT, '0);
    send_item(KIND_INSERT, AngleW'(1));
    send_item(KIND_INSERT, AngleW'(2));
    send_item(KIND_CLEAR, '0);
  endtask

  // Gap and thin limits at their extremes and both thinning parities.
  task automatic test_register_extremes();
    logic [AngleW-1:0] base;
    send_idle_pct  = 15;
    sink_stall_pct = 15;
    for (int c = 0; c < 5; c++) begin
      case (c)
        0:       config_all('0, ThinLimitRst, '0);
        1:       config_all(AngleMax, AngleMax, '0);
        2:       config_all(GapLimitRst, ThinLimitRst, rand_angle() | AngleW'(1));
        3:       config_all(AngleMax, '0, AngleMax);
        default: config_all(GapLimitRst, ThinLimitRst, '0);
      endcase
      base = rand_angle();
      send_item(KIND_CLEAR, '0);
      for (int k = 0; k < 8; k++) begin
        send_item(KIND_INSERT, base + AngleW'(k) * AngleW'(FullTurn / 8)
                  + AngleW'($urandom_range(1 << 16)));
      end
      send_item(KIND_INSERT, base + AngleW'($urandom_range(1 << 10)));
      send_item(KIND_INSERT, base - AngleW'($urandom_range(1 << 10)));
      send_item(KIND_CHECK, '0);
    end
  endtask

  // Fill the store with thinning off, then push past its capacity.
  task automatic test_store_full();
    send_idle_pct  = 15;
    sink_stall_pct = 15;
    config_all(GapLimitRst, '0, '0);
    send_item(KIND_CLEAR, '0);
    while (model_count < AccCapacity) send_item(KIND_INSERT, rand_angle());
    repeat (3) send_item(KIND_INSERT, rand_angle());
    send_item(KIND_INSERT, model_angles[$urandom_range(AccCapacity - 1)]);
    send_item(KIND_CHECK, '0);
    // Thinning now bites into the full set.
    config_all(AngleMax, ThinLimitRst, rand_angle());
    repeat (3) send_item(KIND_CHECK, '0);
  endtask

  // Long receiver hold-off while beats keep coming, so the input stalls.
  task automatic test_backpressure();
    for (int r = 0; r < 2; r++) begin
      drain();
      send_idle_pct  = 0;
      sink_stall_pct = 0;
      hold_cycles    = 300 + 100 * r;
      send_item(KIND_CLEAR, '0);
      repeat (12) send_item(KIND_INSERT, rand_angle());
    end
  endtask

  // Random stretches of well-formed sequences with random content and noise.
  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned n_items);
    int unsigned       sent;
    int unsigned       seq_len;
    int unsigned       spread;
    int unsigned       roll;
    logic [AngleW-1:0] base;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) random_config();
      spread  = $urandom_range(5, 12);
      base    = rand_angle();
      seq_len = $urandom_range(8, 60);
      send_item(KIND_CLEAR, rand_angle());
      sent++;
      repeat (seq_len) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          send_item(KIND_INSERT, pick_angle(spread, base));
        end else if (roll < 80) begin
          send_item(KIND_CHECK, rand_angle());
        end else if (roll < 85) begin
          send_item(KindUnused, rand_angle());
        end else if (roll < 88) begin
          send_item(KIND_CLEAR, rand_angle());
        end else if (model_count != 0) begin
          send_item(KIND_INSERT, model_angles[$urandom_range(model_count - 1)]);
        end else begin
          send_item(KIND_INSERT, rand_angle());
        end
        sent++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    in_if.valid    = 1'b0;
    in_if.kind     = KIND_CLEAR;
    in_if.angle    = '0;
    out_if.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CfgGapLimit;
    cfg_wdata      = '0;
    lim_gap        = GapLimitRst;
    lim_thin       = ThinLimitRst;
    par_thin       = 1'b0;
    model_count    = 0;
    last_angle     = '0;
    fail_count     = 0;
    results_seen   = 0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    hold_cycles    = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_register_extremes();
    test_store_full();
    test_backpressure();
    test_random_phase(0, 0, 240);
    test_random_phase(70, 0, 240);
    test_random_phase(0, 70, 240);
    test_random_phase(15, 15, 240);

    drain();
    repeat (250) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results still expected", 0, pending_results.size());
    if (fail_count == 0) begin
      $display("angular_coverage_checker_core regression: pass");
    end else begin
      $display("angular_coverage_checker_core regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20_000_000;
    $display("angular_coverage_checker_core regression: fail");
    $finish;
  end

endmodule
